// ===== design/pld_pkg.sv =====
// shared types and constants for the point-to-line distance pipeline
// no dependencies
package pld_pkg;

  localparam int COORD_BITS = 24;
  localparam int FRAC_BITS  = 8;
  localparam int DIST_BITS  = COORD_BITS + FRAC_BITS + 1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] line_ax;
    logic signed [COORD_BITS-1:0] line_ay;
    logic signed [COORD_BITS-1:0] line_bx;
    logic signed [COORD_BITS-1:0] line_by;
  } in_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] distance;
    logic                 degenerate;
  } out_t;

  // per-stage control that travels beside the data
  typedef struct packed {
    logic valid;
    logic degen;
  } ctl_t;

endpackage

// ===== design/point_line_distance.sv =====
// point-to-line distance: |cross(b-a, p-a)| / |b-a|, fixed point, truncated
// depends on pld_pkg, pld_div, pld_sqrt
//
//   channel  | ports                          | payload
//   ---------+--------------------------------+---------------------------
//   input    | in_valid, in_ready, in_data    | pld_pkg::in_t (p, a, b)
//   result   | out_valid, out_ready, out_data | pld_pkg::out_t
//
// one item per cycle while results are taken; the pipeline is 6 front stages
// plus one divider stage per quotient bit (2*(COORD_BITS+FRAC_BITS+1) = 66)
// plus one root stage per result bit (33)
// the whole pipeline advances together; it holds while the last stage has a
// result that is not taken, so a stall loses and repeats nothing
// synchronous reset clears only the control bits (valid and degenerate flags)
module point_line_distance (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pld_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output pld_pkg::out_t out_data
);

  localparam int W   = pld_pkg::COORD_BITS;
  localparam int F   = pld_pkg::FRAC_BITS;
  localparam int DW  = W + 1;              // coordinate difference
  localparam int PW  = 2 * DW;             // signed product
  localparam int CRW = PW + 1;             // signed cross product
  localparam int DB  = 2 * W + 2;          // squared length
  localparam int CB  = 2 * W + 1;          // cross magnitude
  localparam int K   = (CB + 1) / 2;       // low half for the split square
  localparam int HB  = CB - K;
  localparam int NB  = 2 * CB + 2 * F;     // dividend
  localparam int SB  = W + F + 1;          // result bits
  localparam int QB  = 2 * SB;             // quotient bits
  localparam int HI  = NB - QB;            // dividend bits below the divisor

  logic en;
  pld_pkg::ctl_t div_ctl, sq_ctl;
  logic [QB-1:0] quo;
  logic [SB-1:0] root;

  // global advance: move when the output slot is free or being emptied
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: differences
  logic                 v1_r;
  logic signed [DW-1:0] dx_r, dy_r, wx_r, wy_r;
  // stage 2: products
  logic                 v2_r;
  logic signed [PW-1:0] p_dxwy_r, p_dywx_r, sq_dx_r, sq_dy_r, sq_wx_r, sq_wy_r;
  // stage 3: cross, squared length, squared distance to a
  logic                  v3_r;
  logic signed [CRW-1:0] cross_r;
  logic [DB-1:0]         den3_r, dsq3_r;
  // stage 4: magnitude and degenerate flag
  pld_pkg::ctl_t c4_r;
  logic [CB-1:0] cmag_r;
  logic [DB-1:0] den4_r, dsq4_r;
  // stage 5: split square of the cross magnitude
  pld_pkg::ctl_t c5_r;
  logic [2*HB-1:0]  hh_r;
  logic [HB+K-1:0]  hl_r;
  logic [2*K-1:0]   ll_r;
  logic [DB-1:0]    den5_r, dsq5_r;
  // stage 6: dividend
  pld_pkg::ctl_t c6_r;
  logic [NB-1:0] num_r;
  logic [DB-1:0] den6_r;

  logic signed [DW-1:0] dx_nxt, dy_nxt, wx_nxt, wy_nxt;
  logic [CB-1:0]        cmag_nxt;
  logic                 degen_nxt;
  logic [NB-1:0]        num_nxt;

  always_comb begin
    dx_nxt = DW'(in_data.line_bx) - DW'(in_data.line_ax);
    dy_nxt = DW'(in_data.line_by) - DW'(in_data.line_ay);
    wx_nxt = DW'(in_data.point_x) - DW'(in_data.line_ax);
    wy_nxt = DW'(in_data.point_y) - DW'(in_data.line_ay);
    // sign extension of each coordinate before the subtract
    dx_nxt = $signed({in_data.line_bx[W-1], in_data.line_bx})
           - $signed({in_data.line_ax[W-1], in_data.line_ax});
    dy_nxt = $signed({in_data.line_by[W-1], in_data.line_by})
           - $signed({in_data.line_ay[W-1], in_data.line_ay});
    wx_nxt = $signed({in_data.point_x[W-1], in_data.point_x})
           - $signed({in_data.line_ax[W-1], in_data.line_ax});
    wy_nxt = $signed({in_data.point_y[W-1], in_data.point_y})
           - $signed({in_data.line_ay[W-1], in_data.line_ay});
    degen_nxt = (den3_r == '0);
    cmag_nxt  = cross_r[CRW-1] ? CB'(-cross_r) : CB'(cross_r);
    // coincident line points: the dividend is the squared distance to a
    if (c5_r.degen) begin
      num_nxt = NB'(dsq5_r) << (2 * F);
    end else begin
      num_nxt = ((NB'(hh_r) << (2 * K)) + (NB'(hl_r) << (K + 1)) + NB'(ll_r)) << (2 * F);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      c4_r <= '0;
      c5_r <= '0;
      c6_r <= '0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      c4_r <= '{valid: v3_r, degen: degen_nxt};
      c5_r <= c4_r;
      c6_r <= c5_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r     <= dx_nxt;
      dy_r     <= dy_nxt;
      wx_r     <= wx_nxt;
      wy_r     <= wy_nxt;
      p_dxwy_r <= dx_r * wy_r;
      p_dywx_r <= dy_r * wx_r;
      sq_dx_r  <= dx_r * dx_r;
      sq_dy_r  <= dy_r * dy_r;
      sq_wx_r  <= wx_r * wx_r;
      sq_wy_r  <= wy_r * wy_r;
      cross_r  <= CRW'(p_dxwy_r) - CRW'(p_dywx_r);
      den3_r   <= DB'(sq_dx_r) + DB'(sq_dy_r);
      dsq3_r   <= DB'(sq_wx_r) + DB'(sq_wy_r);
      cmag_r   <= cmag_nxt;
      den4_r   <= degen_nxt ? DB'(1) : den3_r;
      dsq4_r   <= dsq3_r;
      hh_r     <= cmag_r[CB-1:K] * cmag_r[CB-1:K];
      hl_r     <= cmag_r[CB-1:K] * cmag_r[K-1:0];
      ll_r     <= cmag_r[K-1:0] * cmag_r[K-1:0];
      den5_r   <= den4_r;
      dsq5_r   <= dsq4_r;
      num_r    <= num_nxt;
      den6_r   <= den5_r;
    end
  end

  pld_div #(
    .DEN_BITS (DB),
    .QUO_BITS (QB),
    .HI_BITS  (HI)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .ctl_i  (c6_r),
    .num_hi (num_r[NB-1:QB]),
    .num_lo (num_r[QB-1:0]),
    .den    (den6_r),
    .ctl_o  (div_ctl),
    .quo    (quo)
  );

  pld_sqrt #(
    .ROOT_BITS (SB)
  ) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctl_i (div_ctl),
    .rad   (quo),
    .ctl_o (sq_ctl),
    .root  (root)
  );

  assign out_valid           = sq_ctl.valid;
  assign out_data.distance   = root;
  assign out_data.degenerate = sq_ctl.degen;

  // coincident line points leave no cross product
  a_degen_cross : assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && (den3_r == '0) |-> (cross_r == '0))
    else $error("nonzero cross product with zero line length");

  // a degenerate item divides by one
  a_degen_den : assert property (@(posedge clk) disable iff (!rst_n)
    c4_r.valid && c4_r.degen |-> (den4_r == DB'(1)))
    else $error("degenerate item with divisor other than one");

  // reset empties the pipeline
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

// ===== design/pld_div.sv =====
// pipelined restoring divider, one quotient bit per stage
// depends on pld_pkg (ctl_t)
module pld_div #(
  parameter int DEN_BITS = 50,
  parameter int QUO_BITS = 66,
  parameter int HI_BITS  = 48
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  pld_pkg::ctl_t       ctl_i,
  input  logic [HI_BITS-1:0]  num_hi,
  input  logic [QUO_BITS-1:0] num_lo,
  input  logic [DEN_BITS-1:0] den,
  output pld_pkg::ctl_t       ctl_o,
  output logic [QUO_BITS-1:0] quo
);

  pld_pkg::ctl_t       ctl_r [QUO_BITS];
  logic [DEN_BITS-1:0] rem_r [QUO_BITS];
  logic [DEN_BITS-1:0] den_r [QUO_BITS];
  logic [QUO_BITS-1:0] nq_r  [QUO_BITS];

  for (genvar g = 0; g < QUO_BITS; g++) begin : g_stage
    pld_pkg::ctl_t       ctl_in;
    logic [DEN_BITS-1:0] rem_in;
    logic [DEN_BITS-1:0] den_in;
    logic [QUO_BITS-1:0] nq_in;
    logic [DEN_BITS:0]   sh;
    logic                ge;
    logic [DEN_BITS-1:0] rem_nxt;
    logic [QUO_BITS-1:0] nq_nxt;

    if (g == 0) begin : g_first
      assign ctl_in = ctl_i;
      assign rem_in = DEN_BITS'(num_hi);
      assign den_in = den;
      assign nq_in  = num_lo;
    end else begin : g_next
      assign ctl_in = ctl_r[g-1];
      assign rem_in = rem_r[g-1];
      assign den_in = den_r[g-1];
      assign nq_in  = nq_r[g-1];
    end

    always_comb begin
      sh      = {rem_in, nq_in[QUO_BITS-1]};
      ge      = (sh >= {1'b0, den_in});
      rem_nxt = ge ? DEN_BITS'(sh - {1'b0, den_in}) : sh[DEN_BITS-1:0];
      nq_nxt  = {nq_in[QUO_BITS-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[g] <= '0;
      end else if (en) begin
        ctl_r[g] <= ctl_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= rem_nxt;
        den_r[g] <= den_in;
        nq_r[g]  <= nq_nxt;
      end
    end
  end

  assign ctl_o = ctl_r[QUO_BITS-1];
  assign quo   = nq_r[QUO_BITS-1];

endmodule

// ===== design/pld_sqrt.sv =====
// pipelined integer square root, one root bit per stage
// depends on pld_pkg (ctl_t)
module pld_sqrt #(
  parameter int ROOT_BITS = 33
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  pld_pkg::ctl_t            ctl_i,
  input  logic [2*ROOT_BITS-1:0]   rad,
  output pld_pkg::ctl_t            ctl_o,
  output logic [ROOT_BITS-1:0]     root
);

  localparam int RAD_BITS = 2 * ROOT_BITS;
  localparam int REM_BITS = ROOT_BITS + 2;

  pld_pkg::ctl_t        ctl_r  [ROOT_BITS];
  logic [RAD_BITS-1:0]  rad_r  [ROOT_BITS];
  logic [REM_BITS-1:0]  rem_r  [ROOT_BITS];
  logic [ROOT_BITS-1:0] root_r [ROOT_BITS];

  for (genvar g = 0; g < ROOT_BITS; g++) begin : g_stage
    pld_pkg::ctl_t        ctl_in;
    logic [RAD_BITS-1:0]  rad_in;
    logic [REM_BITS-1:0]  rem_in;
    logic [ROOT_BITS-1:0] root_in;
    logic [REM_BITS+1:0]  t;
    logic [REM_BITS+1:0]  trial;
    logic                 ge;
    logic [REM_BITS-1:0]  rem_nxt;
    logic [ROOT_BITS-1:0] root_nxt;
    logic [RAD_BITS-1:0]  rad_nxt;

    if (g == 0) begin : g_first
      assign ctl_in  = ctl_i;
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign ctl_in  = ctl_r[g-1];
      assign rad_in  = rad_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
    end

    always_comb begin
      t        = {rem_in, rad_in[RAD_BITS-1 -: 2]};
      trial    = (REM_BITS+2)'({root_in, 2'b01});
      ge       = (t >= trial);
      rem_nxt  = ge ? REM_BITS'(t - trial) : REM_BITS'(t);
      root_nxt = {root_in[ROOT_BITS-2:0], ge};
      rad_nxt  = {rad_in[RAD_BITS-3:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[g] <= '0;
      end else if (en) begin
        ctl_r[g] <= ctl_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[g]  <= rad_nxt;
        rem_r[g]  <= rem_nxt;
        root_r[g] <= root_nxt;
      end
    end
  end

  assign ctl_o = ctl_r[ROOT_BITS-1];
  assign root  = root_r[ROOT_BITS-1];

endmodule
